@@ rtl/dhfk_pkg.sv @@
// ----------------------------------------------------------------------------
// dhfk_pkg: shared types and constants for the forward kinematics core
// fixed-point constants, arctangent table and sequencer state codes
// ----------------------------------------------------------------------------
package dhfk_pkg;

  localparam int MaxJoints = 8;
  localparam int JntW      = 4;

  localparam logic signed [19:0] Q16Pi     = 20'sd205887;
  localparam logic signed [19:0] Q16TwoPi  = 20'sd411775;
  localparam logic signed [19:0] Q16HalfPi = 20'sd102944;
  localparam logic signed [19:0] CordicX0  = 20'sd39797;
  localparam logic signed [15:0] RotOne    = 16'sd16384;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_CORDIC,
    ST_LINK,
    ST_POS,
    ST_ROT,
    ST_COMMIT,
    ST_OUT
  } state_e;

  function automatic logic signed [19:0] atan_lut(input logic [3:0] i);
    logic signed [19:0] r;
    case (i)
      4'd0:  r = 20'sd51472;
      4'd1:  r = 20'sd30386;
      4'd2:  r = 20'sd16055;
      4'd3:  r = 20'sd8150;
      4'd4:  r = 20'sd4091;
      4'd5:  r = 20'sd2047;
      4'd6:  r = 20'sd1024;
      4'd7:  r = 20'sd512;
      4'd8:  r = 20'sd256;
      4'd9:  r = 20'sd128;
      4'd10: r = 20'sd64;
      4'd11: r = 20'sd32;
      4'd12: r = 20'sd16;
      4'd13: r = 20'sd8;
      4'd14: r = 20'sd4;
      default: r = 20'sd2;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/dhfk_cordic.sv @@
// ----------------------------------------------------------------------------
// dhfk_cordic: dual rotation-mode cordic
// one micro-rotation per cycle on theta and alpha side by side, 16 steps
// ----------------------------------------------------------------------------
module dhfk_cordic (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [19:0] ang_t_i,
  input  logic signed [19:0] ang_a_i,
  output logic               done_o,
  output logic signed [19:0] cos_t_o,
  output logic signed [19:0] sin_t_o,
  output logic signed [19:0] cos_a_o,
  output logic signed [19:0] sin_a_o
);
  import dhfk_pkg::*;

  logic signed [19:0] xt_q, yt_q, zt_q, xa_q, ya_q, za_q;
  logic [3:0] i_q;
  logic busy_q, nt_q, na_q, done_q;

  // fold into [-pi/2, pi/2]; returns folded angle and negate flag
  function automatic logic [20:0] fold(input logic signed [19:0] a0);
    logic signed [19:0] a;
    logic n;
    a = a0;
    n = 1'b0;
    if (a > Q16Pi) a = a - Q16TwoPi;
    else if (a < -Q16Pi) a = a + Q16TwoPi;
    if (a > Q16HalfPi) begin
      a = a - Q16Pi;
      n = 1'b1;
    end else if (a < -Q16HalfPi) begin
      a = a + Q16Pi;
      n = 1'b1;
    end
    return {n, a};
  endfunction

  logic [20:0] ft, fa;
  assign ft = fold(ang_t_i);
  assign fa = fold(ang_a_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        i_q    <= '0;
      end else if (busy_q) begin
        i_q <= i_q + 4'd1;
        if (i_q == 4'd15) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      xt_q <= CordicX0; yt_q <= '0; zt_q <= ft[19:0]; nt_q <= ft[20];
      xa_q <= CordicX0; ya_q <= '0; za_q <= fa[19:0]; na_q <= fa[20];
    end else if (busy_q) begin
      if (!zt_q[19]) begin
        xt_q <= xt_q - (yt_q >>> i_q); yt_q <= yt_q + (xt_q >>> i_q);
        zt_q <= zt_q - atan_lut(i_q);
      end else begin
        xt_q <= xt_q + (yt_q >>> i_q); yt_q <= yt_q - (xt_q >>> i_q);
        zt_q <= zt_q + atan_lut(i_q);
      end
      if (!za_q[19]) begin
        xa_q <= xa_q - (ya_q >>> i_q); ya_q <= ya_q + (xa_q >>> i_q);
        za_q <= za_q - atan_lut(i_q);
      end else begin
        xa_q <= xa_q + (ya_q >>> i_q); ya_q <= ya_q - (xa_q >>> i_q);
        za_q <= za_q + atan_lut(i_q);
      end
    end
  end

  assign done_o  = done_q;
  assign cos_t_o = nt_q ? -xt_q : xt_q;
  assign sin_t_o = nt_q ? -yt_q : yt_q;
  assign cos_a_o = na_q ? -xa_q : xa_q;
  assign sin_a_o = na_q ? -ya_q : ya_q;
endmodule

@@ rtl/dhfk_mac.sv @@
// ----------------------------------------------------------------------------
// dhfk_mac: shared multiply-accumulate unit
// one signed 24x20 product per cycle while enabled, into a wide accumulator
// ----------------------------------------------------------------------------
module dhfk_mac (
  input  logic               clk_i,
  input  logic               clr_i,
  input  logic               en_i,
  input  logic signed [23:0] a_i,
  input  logic signed [19:0] b_i,
  output logic signed [47:0] acc_o
);
  logic signed [47:0] acc_q;
  logic signed [43:0] prod;

  assign prod = a_i * b_i;

  always_ff @(posedge clk_i) begin
    if (clr_i) acc_q <= '0;
    else if (en_i) acc_q <= acc_q + 48'(prod);
  end

  assign acc_o = acc_q;
endmodule

@@ rtl/dh_forward_kinematics_chain_core.sv @@
// ----------------------------------------------------------------------------
// dh_forward_kinematics_chain_core: serial denavit-hartenberg chain
// per joint: cordic sin/cos, link entries and 3x4 transform update on one mac
// ----------------------------------------------------------------------------
// A joint beat runs from acceptance until ready again through these steps:
// fold the angles and start the cordic, run the 16 cordic steps (theta and
// alpha side by side) up to the done flag, form the six link products (each
// after an accumulator clear, plus the last result), then the position (three
// products and a result per row) and the rotation (the same per entry) on the
// single shared multiplier, then commit. A tip beat then loads the output
// register, which holds the result until taken; the next joint is not taken
// meanwhile. A joint past the joint limit is dropped, and on a tip beat the
// output register is still loaded.
module dh_forward_kinematics_chain_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // joint_angle[15:0], angle_offset[31:16], link_length[49:32],
  // link_offset[67:50], link_twist[83:68], zeros[87:84]
  input  logic [87:0]  s_axis_tdata,
  input  logic         s_axis_tlast,   // last_joint
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // rot_00..rot_22 [143:0] 16 bits each, pos_x[167:144], pos_y[191:168],
  // pos_z[215:192]
  output logic [215:0] m_axis_tdata
);
  import dhfk_pkg::*;

  state_e state_q, state_d;
  logic signed [15:0] rot_q [9];
  logic signed [15:0] nr_q  [9];
  logic signed [23:0] pos_q [3];
  logic signed [19:0] ra_q  [9];
  logic signed [19:0] pa_q  [3];
  logic [JntW-1:0] jnt_q;
  logic [4:0] k_q;          // entry index
  logic [1:0] t_q;          // product index within entry, 3 = result cycle
  logic last_q;
  logic signed [19:0] ang_t_q, ang_a_q, a_q, d_q;
  logic [215:0] out_q;
  logic ovalid_q;

  logic c_start, c_done;
  logic signed [19:0] ct, st, ca, sa;

  dhfk_cordic u_cordic (
    .clk_i, .rst_ni, .start_i(c_start), .ang_t_i(ang_t_q), .ang_a_i(ang_a_q),
    .done_o(c_done), .cos_t_o(ct), .sin_t_o(st), .cos_a_o(ca), .sin_a_o(sa)
  );

  logic mclr, men;
  logic signed [23:0] ma;
  logic signed [19:0] mb;
  logic signed [47:0] acc;

  dhfk_mac u_mac (.clk_i, .clr_i(mclr), .en_i(men), .a_i(ma), .b_i(mb), .acc_o(acc));

  logic in_acc;
  assign s_axis_tready = (state_q == ST_IDLE) && !ovalid_q;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // index helpers
  logic [1:0] ri, cj;
  logic [3:0] ia, ib;
  always_comb begin
    ri = 2'd0; cj = 2'd0;
    // position pass walks rows, rotation pass walks entries
    if (state_q == ST_POS) begin
      ri = k_q[1:0];
    end else begin
      case (k_q)
        5'd0, 5'd1, 5'd2: ri = 2'd0;
        5'd3, 5'd4, 5'd5: ri = 2'd1;
        default: ri = 2'd2;
      endcase
    end
    cj = 2'(k_q - 5'(ri) * 5'd3);
    ia = 4'(ri) * 4'd3 + 4'(t_q == 2'd3 ? 2'd0 : t_q);
    ib = 4'(t_q == 2'd3 ? 2'd0 : t_q) * 4'd3 + 4'(cj);
  end

  logic signed [47:0] rnd16, rnd14, pnew;
  assign rnd16 = (acc + 48'sd32768) >>> 16;
  assign rnd14 = (acc + 48'sd8192) >>> 14;
  assign pnew  = rnd14 + 48'(pos_q[ri]);

  function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
    if (v > 48'sd32767) return 16'sh7fff;
    if (v < -48'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction
  function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
    if (v > 48'sd8388607) return 24'sh7fffff;
    if (v < -48'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  always_comb begin
    state_d = state_q;
    c_start = 1'b0;
    mclr = 1'b0; men = 1'b0; ma = '0; mb = '0;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_PREP;
      ST_PREP: begin
        if (jnt_q < JntW'(MaxJoints)) begin
          c_start = 1'b1; state_d = ST_CORDIC;
        end else state_d = last_q ? ST_OUT : ST_IDLE;
      end
      ST_CORDIC: begin
        mclr = 1'b1;
        if (c_done) state_d = ST_LINK;
      end
      ST_LINK: begin
        // link products: st*ca, st*sa, ct*ca, ct*sa, a*ct, a*st; each after an accumulator clear
        if (!k_q[0]) begin
          mclr = 1'b1;
        end else begin
          men = 1'b1;
          case (k_q[4:1])
            4'd0: begin ma = 24'(st); mb = ca; end
            4'd1: begin ma = 24'(st); mb = sa; end
            4'd2: begin ma = 24'(ct); mb = ca; end
            4'd3: begin ma = 24'(ct); mb = sa; end
            4'd4: begin ma = 24'(a_q); mb = ct; end
            default: begin ma = 24'(a_q); mb = st; end
          endcase
        end
        if (k_q == 5'd12) state_d = ST_POS;
      end
      ST_POS: begin
        if (t_q == 2'd3) mclr = 1'b1;
        else begin
          men = 1'b1; ma = 24'(rot_q[ia]); mb = pa_q[t_q];
        end
        if (t_q == 2'd3 && k_q == 5'd2) state_d = ST_ROT;
      end
      ST_ROT: begin
        if (t_q == 2'd3) mclr = 1'b1;
        else begin
          men = 1'b1; ma = 24'(rot_q[ia]); mb = ra_q[ib];
        end
        if (t_q == 2'd3 && k_q == 5'd8) state_d = ST_COMMIT;
      end
      ST_COMMIT: state_d = last_q ? ST_OUT : ST_IDLE;
      ST_OUT: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
      jnt_q    <= '0;
      k_q      <= '0;
      t_q      <= '0;
      for (int n = 0; n < 9; n++) rot_q[n] <= (n % 4 == 0) ? RotOne : 16'sd0;
      for (int n = 0; n < 3; n++) pos_q[n] <= '0;
    end else begin
      state_q <= state_d;
      if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
      case (state_q)
        ST_CORDIC: begin k_q <= '0; t_q <= '0; end
        ST_LINK: begin
          if (k_q[0] == 1'b0 && k_q != 5'd0) begin
            case (k_q[4:1])
              4'd1: ra_q[1] <= -rnd16[19:0];
              4'd2: ra_q[2] <= rnd16[19:0];
              4'd3: ra_q[4] <= rnd16[19:0];
              4'd4: ra_q[5] <= -rnd16[19:0];
              4'd5: pa_q[0] <= rnd16[19:0];
              default: pa_q[1] <= rnd16[19:0];
            endcase
          end
          if (k_q == 5'd0) begin
            ra_q[0] <= ct; ra_q[3] <= st; ra_q[6] <= '0;
            ra_q[7] <= sa; ra_q[8] <= ca; pa_q[2] <= d_q;
          end
          k_q <= (k_q == 5'd12) ? 5'd0 : k_q + 5'd1;
        end
        ST_POS, ST_ROT: begin
          t_q <= t_q + 2'd1;
          if (t_q == 2'd3) begin
            if (state_q == ST_POS) pos_q[ri] <= sat24(pnew);
            else nr_q[k_q[3:0]] <= sat16(rnd16);
            k_q <= ((state_q == ST_POS && k_q == 5'd2) || k_q == 5'd8) ? 5'd0
                   : k_q + 5'd1;
          end
        end
        ST_COMMIT: begin
          for (int n = 0; n < 9; n++) rot_q[n] <= nr_q[n];
          jnt_q <= jnt_q + JntW'(1);
        end
        ST_OUT: begin
          ovalid_q <= 1'b1;
          for (int n = 0; n < 9; n++) rot_q[n] <= (n % 4 == 0) ? RotOne : 16'sd0;
          for (int n = 0; n < 3; n++) pos_q[n] <= '0;
          jnt_q <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ang_t_q <= (20'(signed'(s_axis_tdata[15:0])) + 20'(signed'(s_axis_tdata[31:16]))) <<< 3;
      a_q     <= 20'(signed'(s_axis_tdata[49:32]));
      d_q     <= 20'(signed'(s_axis_tdata[67:50]));
      ang_a_q <= 20'(signed'(s_axis_tdata[83:68])) <<< 3;
      last_q  <= s_axis_tlast;
    end
    if (state_q == ST_OUT) begin
      for (int n = 0; n < 9; n++) out_q[n*16 +: 16] <= rot_q[n];
      for (int n = 0; n < 3; n++) out_q[144 + n*24 +: 24] <= pos_q[n];
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = out_q;
endmodule

@@ rtl/dhfk_checker.sv @@
// ----------------------------------------------------------------------------
// dhfk_checker: port-level checks for the forward kinematics core
// result and joint handshakes over time
// ----------------------------------------------------------------------------
module dhfk_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [215:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped while stalled");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("joint taken while busy");
  a_noin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("joint taken with pending result");
  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
    else $error("result too early");
endmodule

bind dh_forward_kinematics_chain_core dhfk_checker u_dhfk_checker (.*);

@@ tb/tb_dh_forward_kinematics_chain_core.sv @@
// ----------------------------------------------------------------------------
// tb_dh_forward_kinematics_chain_core: self-checking bench for the dh chain
// drives joint beats with random gaps, predicts each tip pose in fixed point
// and compares every output beat field by field in arrival order
// ----------------------------------------------------------------------------
module tb_dh_forward_kinematics_chain_core;
  import dhfk_pkg::*;

  typedef struct {
    logic signed [15:0] rot[9];
    logic signed [23:0] pos[3];
  } pose_t;

  class pose_board;
    longint rot_q[9];
    longint pos_q[3];
    int     n_joint;
    pose_t  pending[$];
    int     errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      for (int k = 0; k < 9; k++) rot_q[k] = (k % 4 == 0) ? RotOne : 0;
      for (int k = 0; k < 3; k++) pos_q[k] = 0;
      n_joint = 0;
    endfunction

    function longint fshr(longint v, int s);
      return v >>> s;
    endfunction

    function longint rshr(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function longint sat(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function void sincos(longint ang, output longint c, output longint s);
      longint x, y, z, dx, dy;
      bit neg;
      neg = 0;
      x = CordicX0;
      y = 0;
      if (ang > Q16Pi) ang -= Q16TwoPi;
      else if (ang < -Q16Pi) ang += Q16TwoPi;
      if (ang > Q16HalfPi) begin
        ang -= Q16Pi; neg = 1;
      end else if (ang < -Q16HalfPi) begin
        ang += Q16Pi; neg = 1;
      end
      z = ang;
      for (int i = 0; i < 16; i++) begin
        dx = fshr(y, i);
        dy = fshr(x, i);
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_lut(i[3:0]);
        end else begin
          x += dx; y -= dy; z += atan_lut(i[3:0]);
        end
      end
      c = neg ? -x : x;
      s = neg ? -y : y;
    endfunction

    // apply one joint beat, queue a pose on the tip beat
    function void note_joint(logic [87:0] d, logic tip);
      longint th, a, dz, al, ct, st, ca, sa, acc;
      longint ra[9], pa[3], nr[9];
      pose_t p;
      th = longint'($signed(d[15:0])) + longint'($signed(d[31:16]));
      a  = $signed(d[49:32]);
      dz = $signed(d[67:50]);
      al = $signed(d[83:68]);
      if (n_joint < MaxJoints) begin
        sincos(th * 8, ct, st);
        sincos(al * 8, ca, sa);
        ra[0] = ct; ra[1] = -rshr(st * ca, 16); ra[2] = rshr(st * sa, 16);
        ra[3] = st; ra[4] = rshr(ct * ca, 16);  ra[5] = -rshr(ct * sa, 16);
        ra[6] = 0;  ra[7] = sa;                 ra[8] = ca;
        pa[0] = rshr(a * ct, 16);
        pa[1] = rshr(a * st, 16);
        pa[2] = dz;
        for (int i = 0; i < 3; i++) begin
          acc = 0;
          for (int k = 0; k < 3; k++) acc += rot_q[i*3+k] * pa[k];
          pos_q[i] = sat(rshr(acc, 14) + pos_q[i], -8388608, 8388607);
        end
        for (int i = 0; i < 3; i++)
          for (int j = 0; j < 3; j++) begin
            acc = 0;
            for (int k = 0; k < 3; k++) acc += rot_q[i*3+k] * ra[k*3+j];
            nr[i*3+j] = sat(rshr(acc, 16), -32768, 32767);
          end
        for (int k = 0; k < 9; k++) rot_q[k] = nr[k];
        n_joint++;
      end
      if (tip) begin
        for (int k = 0; k < 9; k++) p.rot[k] = 16'(rot_q[k]);
        for (int k = 0; k < 3; k++) p.pos[k] = 24'(pos_q[k]);
        pending.push_back(p);
        clear();
      end
    endfunction

    function void check_pose(logic [215:0] q);
      pose_t p;
      if (pending.size() == 0) begin
        $display("%0t: unexpected pose beat %h", $time, q);
        errors++;
        return;
      end
      p = pending.pop_front();
      for (int k = 0; k < 9; k++)
        if (q[16*k +: 16] !== p.rot[k]) begin
          $display("%0t: rot[%0d] expected %0d actual %0d", $time, k,
                   p.rot[k], $signed(q[16*k +: 16]));
          errors++;
        end
      for (int k = 0; k < 3; k++)
        if (q[144+24*k +: 24] !== p.pos[k]) begin
          $display("%0t: pos[%0d] expected %0d actual %0d", $time, k,
                   p.pos[k], $signed(q[144+24*k +: 24]));
          errors++;
        end
    endfunction
  endclass

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [87:0]  s_axis_tdata;
  logic         s_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [215:0] m_axis_tdata;

  pose_board board;
  bit        sink_quiet;
  int        idle_cycles;

  localparam int WatchLimit = 5000;

  dh_forward_kinematics_chain_core dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always begin
    clk_i = 1'b0; #6;
    clk_i = 1'b1; #6;
  end

  function automatic logic [17:0] rnd18();
    return 18'($urandom);
  endfunction

  // one joint beat, with a random gap first unless burst is set
  task automatic send_joint(logic [15:0] ang, logic [15:0] offs, logic [17:0] a,
                            logic [17:0] d, logic [15:0] tw, logic tip, bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= {4'b0, tw, d, a, offs, ang};
    s_axis_tlast  <= tip;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_joint(s_axis_tdata, s_axis_tlast);
    @(negedge clk_i);
  endtask

  task automatic send_random(int n_joint, bit tip, bit burst);
    logic [15:0] ang, tw;
    for (int j = 0; j < n_joint; j++) begin
      ang = (($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 51472)));
      tw  = 16'($urandom);
      if ($urandom_range(0, 3) == 0) tw = 16'($urandom_range(0, 3)) * 16'sd12868;
      send_joint(ang, 16'($urandom), ($urandom_range(0, 7) == 0) ? rnd18()
                 : 18'($signed(16'($urandom))), ($urandom_range(0, 7) == 0) ? rnd18()
                 : 18'($signed(16'($urandom))), tw, tip && (j == n_joint - 1), burst);
    end
  endtask

  // sink inserts a random ready gap before each beat, none while quiet
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      int hold_n;
      hold_n = sink_quiet ? 0 : $urandom_range(0, 5);
      if (hold_n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_n) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_pose(m_axis_tdata);

  // watchdog on cycles with no accepted beat
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int tail;
    board = new();
    idle_cycles = 0;
    sink_quiet = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: extremes, wrap, single joint, overflow of joint count
    send_joint(16'h7fff, 16'h7fff, 18'h1ffff, 18'h1ffff, 16'h7fff, 1'b1, 0);
    send_joint(16'h8000, 16'h8000, 18'h20000, 18'h20000, 16'h8000, 1'b1, 0);
    send_joint(16'h0000, 16'h0000, 18'h0, 18'h0, 16'h0, 1'b1, 0);
    send_joint(16'd12868, 16'h0, 18'd65536, 18'd0, 16'd12868, 1'b0, 0);
    send_joint(16'hcdbc, 16'd25736, 18'h3ffff, 18'd1, 16'hcdbc, 1'b1, 0);
    for (int j = 0; j < 11; j++)
      send_joint(16'd25736, 16'd100, 18'h1ffff, 18'h1ffff, 16'd0, j == 10, 1);
    for (int j = 0; j < 8; j++)
      send_joint(16'h0, 16'h0, 18'h1ffff, 18'h20000, 16'd12868, j == 7, 0);

    // random chains, mostly 1..8 joints, some past the limit
    while (board.pending.size() < 10000 && tail < 1800) begin
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
      sink_quiet = ($urandom_range(0, 4) == 0);
      send_random(n, 1'b1, $urandom_range(0, 4) == 0);
      tail += n;
    end
    s_axis_tvalid <= 1'b0;
    sink_quiet = 0;

    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/dhfk_pkg.sv
rtl/dhfk_cordic.sv
rtl/dhfk_mac.sv
rtl/dh_forward_kinematics_chain_core.sv
rtl/dhfk_checker.sv
tb/tb_dh_forward_kinematics_chain_core.sv
